// File: rtl/gbdc_pkg.sv
// Shared types and constants for the gyro bias deadband conditioner.
`default_nettype none

package gbdc_pkg;

	localparam int STAMP_W = 32;
	localparam int RATE_W  = 24;
	localparam int CFG_W   = 23;
	localparam int TICK_W  = 16;
	localparam int SQ_W    = 2 * RATE_W - 1;

	localparam int GAIN_DIVISOR  = 15000;
	localparam int HALF_DIVISOR  = GAIN_DIVISOR / 2;
	localparam int GAIN_CAP      = 750;
	localparam int GAIN_T_W      = 10;
	localparam int REM_W         = 14;
	localparam int DIGIT_W       = 4;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STILL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_NOM = 3'd4;

	// sequencer strobes to lanes and merge stage
	typedef struct packed {
		logic sq_en;
		logic mul_en;
		logic prep_en;
		logic div_en;
		logic upd_en;
		logic corr_en;
	} ctl_t;

endpackage

`default_nettype wire

// File: rtl/gbdc_in_if.sv
// Input channel: one IMU sample beat.
`default_nettype none

interface gbdc_in_if;
	logic                                   valid;
	logic                                   ready;
	logic        [gbdc_pkg::STAMP_W-1:0]    tick_stamp;
	logic signed [gbdc_pkg::RATE_W-1:0]     gyro_x;
	logic signed [gbdc_pkg::RATE_W-1:0]     gyro_y;
	logic signed [gbdc_pkg::RATE_W-1:0]     gyro_z;

	modport source (output valid, tick_stamp, gyro_x, gyro_y, gyro_z, input ready);
	modport sink   (input valid, tick_stamp, gyro_x, gyro_y, gyro_z, output ready);
endinterface

`default_nettype wire

// File: rtl/gbdc_out_if.sv
// Output channel: one corrected rate beat.
`default_nettype none

interface gbdc_out_if;
	logic                                   valid;
	logic                                   ready;
	logic        [gbdc_pkg::TICK_W-1:0]     step_ticks;
	logic signed [gbdc_pkg::RATE_W-1:0]     rate_x;
	logic signed [gbdc_pkg::RATE_W-1:0]     rate_y;
	logic signed [gbdc_pkg::RATE_W-1:0]     rate_z;
	logic                                   is_still;

	modport source (output valid, step_ticks, rate_x, rate_y, rate_z, is_still, input ready);
	modport sink   (input valid, step_ticks, rate_x, rate_y, rate_z, is_still, output ready);
endinterface

`default_nettype wire

// File: rtl/gbdc_lane.sv
// One axis lane: square, bias EMA with radix-16 divide by 15000, deadband and rounding.
`default_nettype none

module gbdc_lane #(
	parameter int BIAS_EXTRA_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gbdc_pkg::ctl_t                      ctl,
	input  logic signed [gbdc_pkg::RATE_W-1:0]  g,
	input  logic        [gbdc_pkg::GAIN_T_W-1:0] t,
	input  logic        [gbdc_pkg::CFG_W-1:0]   deadband,
	output logic        [gbdc_pkg::SQ_W-1:0]    sq,
	output logic signed [gbdc_pkg::RATE_W-1:0]  rate
);

	localparam int BIAS_W  = gbdc_pkg::RATE_W + BIAS_EXTRA_BITS;
	localparam int PROD_W  = BIAS_W + 1 + gbdc_pkg::GAIN_T_W;
	localparam int NUM_W   = BIAS_W + gbdc_pkg::GAIN_T_W;
	localparam int DIV_CYC = (NUM_W + 7) / 8;
	localparam int DV_W    = DIV_CYC * 8;
	localparam int REM_W   = gbdc_pkg::REM_W;
	localparam int RATE_W  = gbdc_pkg::RATE_W;
	localparam int GAIN_T_W_S = gbdc_pkg::GAIN_T_W;
	localparam logic [BIAS_W+1:0] HALF_LSB = ((BIAS_W+2)'(1) << BIAS_EXTRA_BITS) >> 1;

	typedef struct packed {
		logic [gbdc_pkg::DIGIT_W-1:0] d;
		logic [REM_W-1:0]             r;
	} dstep_t;

	function automatic dstep_t div_digit(input logic [REM_W-1:0] rem,
			input logic [gbdc_pkg::DIGIT_W-1:0] nib);
		logic [REM_W+3:0] x;
		dstep_t           s;
		x   = {rem, nib};
		s.d = '0;
		for (int k = 1; k < 16; k++) begin
			if (x >= (REM_W+4)'(k * gbdc_pkg::GAIN_DIVISOR))
				s.d = gbdc_pkg::DIGIT_W'(k);
		end
		s.r = REM_W'(x - (REM_W+4)'(s.d * gbdc_pkg::GAIN_DIVISOR));
		return s;
	endfunction

	logic        [gbdc_pkg::SQ_W-1:0] sq_s;
	logic signed [PROD_W-1:0]         prod_s;
	logic                             neg_q;
	logic        [DV_W-1:0]           dvd_q;
	logic        [REM_W-1:0]          rem_q;
	logic        [DV_W-1:0]           quo_q;
	logic signed [BIAS_W-1:0]         bias_q;
	logic signed [BIAS_W+1:0]         dz_q;

	logic signed [2*RATE_W-1:0] sq_full;
	logic signed [BIAS_W-1:0]   gext;
	logic signed [BIAS_W:0]     delta;
	logic signed [GAIN_T_W_S:0] t_s;
	logic signed [PROD_W-1:0]   prod;
	logic        [PROD_W-1:0]   prod_mag;
	logic        [NUM_W-1:0]    num;
	dstep_t                     st_hi;
	dstep_t                     st_lo;
	logic        [BIAS_W-2:0]   quo;
	logic signed [BIAS_W:0]     qs;
	logic signed [BIAS_W:0]     bsum;
	logic signed [BIAS_W:0]     v;
	logic signed [BIAS_W:0]     lim;
	logic        [BIAS_W+1:0]   dz_mag;
	logic        [BIAS_W+1:0]   rnd;

	assign sq_full  = g * g;
	assign gext     = BIAS_W'(g) <<< BIAS_EXTRA_BITS;
	assign delta    = (BIAS_W+1)'(gext) - (BIAS_W+1)'(bias_q);
	assign t_s      = $signed({1'b0, t});
	assign prod     = PROD_W'(delta) * PROD_W'(t_s);
	assign prod_mag = prod_s[PROD_W-1] ? PROD_W'(-prod_s) : PROD_W'(prod_s);
	assign num      = prod_mag[NUM_W-1:0] + NUM_W'(gbdc_pkg::HALF_DIVISOR);

	assign st_hi = div_digit(rem_q, dvd_q[DV_W-1 -: 4]);
	assign st_lo = div_digit(st_hi.r, dvd_q[DV_W-5 -: 4]);

	assign quo  = quo_q[BIAS_W-2:0];
	assign qs   = neg_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
	assign bsum = (BIAS_W+1)'(bias_q) + qs;

	assign v   = (BIAS_W+1)'(gext) - (BIAS_W+1)'(bias_q);
	assign lim = $signed((BIAS_W+1)'(deadband) << BIAS_EXTRA_BITS);

	always_ff @(posedge clk) begin
		if (ctl.sq_en)
			sq_s <= sq_full[gbdc_pkg::SQ_W-1:0];
		if (ctl.mul_en)
			prod_s <= prod;
		if (ctl.prep_en) begin
			neg_q <= prod_s[PROD_W-1];
			dvd_q <= DV_W'(num);
			rem_q <= '0;
			quo_q <= '0;
		end else if (ctl.div_en) begin
			dvd_q <= dvd_q << 8;
			rem_q <= st_lo.r;
			quo_q <= {quo_q[DV_W-9:0], st_hi.d, st_lo.d};
		end
		if (ctl.corr_en) begin
			if (v > lim)
				dz_q <= (BIAS_W+2)'(v) - (BIAS_W+2)'(lim);
			else if (v < -lim)
				dz_q <= (BIAS_W+2)'(v) + (BIAS_W+2)'(lim);
			else
				dz_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (ctl.upd_en) begin
			if (bsum[BIAS_W] != bsum[BIAS_W-1])
				bias_q <= bsum[BIAS_W] ? {1'b1, {(BIAS_W-1){1'b0}}}
				                       : {1'b0, {(BIAS_W-1){1'b1}}};
			else
				bias_q <= bsum[BIAS_W-1:0];
		end
	end

	// round half away from zero to rate units, then saturate
	assign dz_mag = dz_q[BIAS_W+1] ? (BIAS_W+2)'(-dz_q) : (BIAS_W+2)'(dz_q);
	assign rnd    = (dz_mag + HALF_LSB) >> BIAS_EXTRA_BITS;

	always_comb begin
		if (!dz_q[BIAS_W+1]) begin
			if (rnd > (BIAS_W+2)'((1 << (RATE_W-1)) - 1))
				rate = {1'b0, {(RATE_W-1){1'b1}}};
			else
				rate = $signed(rnd[RATE_W-1:0]);
		end else begin
			if (rnd >= (BIAS_W+2)'(1 << (RATE_W-1)))
				rate = {1'b1, {(RATE_W-1){1'b0}}};
			else
				rate = -$signed(rnd[RATE_W-1:0]);
		end
	end

	assign sq = sq_s;

endmodule

`default_nettype wire

// File: rtl/gbdc_merge.sv
// Merge stage: sums the lane squares and compares against the squared still limit.
`default_nettype none

module gbdc_merge (
	input  logic                                clk,
	input  gbdc_pkg::ctl_t                      ctl,
	input  logic [2:0][gbdc_pkg::SQ_W-1:0]      sq,
	input  logic [gbdc_pkg::CFG_W-1:0]          still_limit,
	output logic                                still
);

	localparam int LIM2_W = 2 * gbdc_pkg::CFG_W;
	localparam int SUM_W  = gbdc_pkg::SQ_W + 1;

	logic [LIM2_W-1:0] lim2_s;
	logic              still_s;
	logic [SUM_W-1:0]  mag2;

	assign mag2 = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);

	always_ff @(posedge clk) begin
		if (ctl.sq_en)
			lim2_s <= LIM2_W'(still_limit) * LIM2_W'(still_limit);
		if (ctl.mul_en)
			still_s <= (mag2 < SUM_W'(lim2_s));
	end

	assign still = still_s;

endmodule

`default_nettype wire

// File: rtl/gyro_bias_deadband_conditioner.sv
// Top level: config registers, tick step logic, sequencer, three axis lanes and merge.
`default_nettype none

// Takes one IMU sample per beat and returns one beat with the tick step, the three
// bias-corrected, deadbanded rates and the still flag. One sample is in work at a time;
// it passes the states SQ, MUL, PREP, DIV, UPD, CORR and DONE before the result is
// registered, and the next sample is taken once the sequencer is back in idle, which
// it reaches as soon as the output register is free. The DIV state holds the bias EMA
// divide by 15000, done as a radix-16 long division at two digits per cycle in each lane.
// A finished result waits in the output register while the next sample is accepted; a
// second result holds in the sequencer until that register frees. Configuration writes
// take effect at the edge that samples cfg_we and belong between samples.
module gyro_bias_deadband_conditioner #(
	parameter int BIAS_EXTRA_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	gbdc_in_if.sink                            imu,
	gbdc_out_if.source                         rates,
	input  logic                               cfg_we,
	input  logic [gbdc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gbdc_pkg::CFG_W-1:0]         cfg_data
);

	localparam int BIAS_W  = gbdc_pkg::RATE_W + BIAS_EXTRA_BITS;
	localparam int NUM_W   = BIAS_W + gbdc_pkg::GAIN_T_W;
	localparam int DIV_CYC = (NUM_W + 7) / 8;
	localparam int CNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
	localparam int TICK_W  = gbdc_pkg::TICK_W;
	localparam int STAMP_W = gbdc_pkg::STAMP_W;
	localparam int RATE_W  = gbdc_pkg::RATE_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SQ   = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_PREP = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_UPD  = 3'd5;
	localparam logic [2:0] S_CORR = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] div_cnt_q;

	logic [gbdc_pkg::CFG_W-1:0] deadband_q;
	logic [gbdc_pkg::CFG_W-1:0] still_lim_q;
	logic [TICK_W-1:0]          tick_min_q;
	logic [TICK_W-1:0]          tick_max_q;
	logic [TICK_W-1:0]          tick_nom_q;

	logic        [STAMP_W-1:0] stamp_q;
	logic        [STAMP_W-1:0] prev_q;
	logic signed [RATE_W-1:0]  g_q [3];
	logic        [TICK_W-1:0]  step_q;

	logic                      out_valid_q;
	logic        [TICK_W-1:0]  out_step_q;
	logic signed [RATE_W-1:0]  out_rate_q [3];
	logic                      out_still_q;

	logic [STAMP_W-1:0]              diff;
	logic                            diff_ok;
	logic [gbdc_pkg::GAIN_T_W-1:0]   t;
	logic                            still;
	logic                            out_free;
	gbdc_pkg::ctl_t                  ctl;
	logic [2:0][gbdc_pkg::SQ_W-1:0]  lane_sq;
	logic signed [RATE_W-1:0]        lane_rate [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q  <= gbdc_pkg::CFG_W'(343);
			still_lim_q <= gbdc_pkg::CFG_W'(2859);
			tick_min_q  <= TICK_W'(5);
			tick_max_q  <= TICK_W'(100);
			tick_nom_q  <= TICK_W'(20);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gbdc_pkg::REG_DEADBAND: deadband_q  <= cfg_data;
				gbdc_pkg::REG_STILL:    still_lim_q <= cfg_data;
				gbdc_pkg::REG_TICK_MIN: tick_min_q  <= cfg_data[TICK_W-1:0];
				gbdc_pkg::REG_TICK_MAX: tick_max_q  <= cfg_data[TICK_W-1:0];
				gbdc_pkg::REG_TICK_NOM: tick_nom_q  <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign diff    = stamp_q - prev_q;
	assign diff_ok = (diff != '0) && (diff >= STAMP_W'(tick_min_q))
	                 && (diff <= STAMP_W'(tick_max_q));
	assign t       = (step_q > TICK_W'(gbdc_pkg::GAIN_CAP))
	                 ? gbdc_pkg::GAIN_T_W'(gbdc_pkg::GAIN_CAP)
	                 : step_q[gbdc_pkg::GAIN_T_W-1:0];
	assign out_free = !out_valid_q || rates.ready;

	assign imu.ready = (state_q == S_IDLE);

	always_comb begin
		ctl.sq_en   = (state_q == S_SQ);
		ctl.mul_en  = (state_q == S_MUL);
		ctl.prep_en = (state_q == S_PREP);
		ctl.div_en  = (state_q == S_DIV);
		ctl.upd_en  = (state_q == S_UPD) && still;
		ctl.corr_en = (state_q == S_CORR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
			prev_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (imu.valid) state_q <= S_SQ;
				S_SQ: begin
					prev_q  <= stamp_q;
					state_q <= S_MUL;
				end
				S_MUL:  state_q <= S_PREP;
				S_PREP: begin
					div_cnt_q <= CNT_W'(DIV_CYC - 1);
					state_q   <= S_DIV;
				end
				S_DIV: begin
					if (div_cnt_q == '0)
						state_q <= S_UPD;
					else
						div_cnt_q <= div_cnt_q - 1'b1;
				end
				S_UPD:  state_q <= S_CORR;
				S_CORR: state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (imu.valid && imu.ready) begin
			stamp_q <= imu.tick_stamp;
			g_q[0]  <= imu.gyro_x;
			g_q[1]  <= imu.gyro_y;
			g_q[2]  <= imu.gyro_z;
		end
		if (state_q == S_SQ)
			step_q <= diff_ok ? diff[TICK_W-1:0] : tick_nom_q;
	end

	for (genvar k = 0; k < 3; k++) begin : g_lane
		gbdc_lane #(
			.BIAS_EXTRA_BITS(BIAS_EXTRA_BITS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.g        (g_q[k]),
			.t        (t),
			.deadband (deadband_q),
			.sq       (lane_sq[k]),
			.rate     (lane_rate[k])
		);
	end

	gbdc_merge u_merge (
		.clk         (clk),
		.ctl         (ctl),
		.sq          (lane_sq),
		.still_limit (still_lim_q),
		.still       (still)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rates.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_step_q    <= step_q;
			out_rate_q[0] <= lane_rate[0];
			out_rate_q[1] <= lane_rate[1];
			out_rate_q[2] <= lane_rate[2];
			out_still_q   <= still;
		end
	end

	assign rates.valid      = out_valid_q;
	assign rates.step_ticks = out_step_q;
	assign rates.rate_x     = out_rate_q[0];
	assign rates.rate_y     = out_rate_q[1];
	assign rates.rate_z     = out_rate_q[2];
	assign rates.is_still   = out_still_q;

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(imu.valid && imu.ready) |=> (state_q == S_SQ))
		else $error("accepted beat did not start the sequence");

	a_step_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (step_q == tick_nom_q
			|| (step_q != '0 && step_q >= tick_min_q && step_q <= tick_max_q)))
		else $error("step outside window and not nominal");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result beat raised outside completion");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DIV) |-> (div_cnt_q == '0))
		else $error("divide counter left running");
`endif

endmodule

`default_nettype wire

// File: sim/gyro_bias_deadband_conditioner_test.sv
// Testbench: directed rows and random register phases, each result checked against a predictor or a given beat.
module gyro_bias_deadband_conditioner_test;
	timeunit 1ns;
	timeprecision 1ps;
	import gbdc_pkg::*;

	typedef struct packed {
		logic        [STAMP_W-1:0] stamp;
		logic signed [RATE_W-1:0]  gx;
		logic signed [RATE_W-1:0]  gy;
		logic signed [RATE_W-1:0]  gz;
	} sample_t;

	typedef struct packed {
		logic        [TICK_W-1:0] step_ticks;
		logic signed [RATE_W-1:0] rate_x;
		logic signed [RATE_W-1:0] rate_y;
		logic signed [RATE_W-1:0] rate_z;
		logic                     is_still;
	} rates_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

	typedef struct {
		row_kind_e            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		sample_t              smp;
		bit                   typed;
		rates_t               want;
	} dir_row_t;

	localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

	localparam int     EXTRA_BITS = 16;
	localparam longint BIAS_ONE   = 64'sd1 <<< EXTRA_BITS;
	localparam longint BIAS_MAX   = (64'sd1 <<< (RATE_W + EXTRA_BITS - 1)) - 1;
	localparam longint BIAS_MIN   = -BIAS_MAX - 1;
	localparam longint RATE_MAX   = (64'sd1 <<< (RATE_W - 1)) - 1;
	localparam longint RATE_MIN   = -RATE_MAX - 1;
	localparam int     PHASES       = 6;
	localparam int     PHASE_ITEMS  = 140;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	gbdc_in_if  imu_ch ();
	gbdc_out_if rate_ch ();

	gyro_bias_deadband_conditioner u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.imu       (imu_ch),
		.rates     (rate_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state and register copy
	logic [CFG_W-1:0]    cfg_deadband = 23'd343;
	logic [CFG_W-1:0]    cfg_still    = 23'd2859;
	logic [TICK_W-1:0]   cfg_tick_min = 16'd5;
	logic [TICK_W-1:0]   cfg_tick_max = 16'd100;
	logic [TICK_W-1:0]   cfg_tick_nom = 16'd20;
	logic [STAMP_W-1:0]  last_stamp   = '0;
	longint              bias_acc [3] = '{0, 0, 0};

	rates_t   rates_due [$];
	dir_row_t dir_rows [$];

	int fault_count = 0;
	int n_samples   = 0;
	int n_results   = 0;
	int n_still     = 0;
	int n_fallback  = 0;
	int n_writes    = 0;
	int long_hold   = 0;
	bit steady      = 1'b0;

	always #10 clk = ~clk;

	function automatic longint div_round(longint num, longint den);
		longint mag;
		mag = (num < 0) ? -num : num;
		mag = (mag + den / 2) / den;
		return (num < 0) ? -mag : mag;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic rates_t predict_conditioned(sample_t s);
		logic [STAMP_W-1:0]       diff;
		logic [TICK_W-1:0]        dt;
		longint                   g [3];
		longint                   mag2, lim, gain_t, v;
		logic signed [RATE_W-1:0] outs [3];
		bit                       still;
		rates_t                   res;
		diff = s.stamp - last_stamp;
		last_stamp = s.stamp;
		if (diff != 0 && diff >= cfg_tick_min && diff <= cfg_tick_max) begin
			dt = diff[TICK_W-1:0];
		end else begin
			dt = cfg_tick_nom;
			n_fallback++;
		end
		g[0] = s.gx;
		g[1] = s.gy;
		g[2] = s.gz;
		mag2 = g[0] * g[0] + g[1] * g[1] + g[2] * g[2];
		lim = cfg_still;
		still = mag2 < lim * lim;
		if (still) begin
			n_still++;
			gain_t = (dt > GAIN_CAP) ? GAIN_CAP : dt;
			for (int k = 0; k < 3; k++)
				bias_acc[k] = clamp(bias_acc[k] +
					div_round((g[k] * BIAS_ONE - bias_acc[k]) * gain_t, GAIN_DIVISOR),
					BIAS_MIN, BIAS_MAX);
		end
		lim = cfg_deadband;
		lim = lim * BIAS_ONE;
		for (int k = 0; k < 3; k++) begin
			v = g[k] * BIAS_ONE - bias_acc[k];
			if (v > lim)
				v = v - lim;
			else if (v < -lim)
				v = v + lim;
			else
				v = 0;
			v = clamp(div_round(v, BIAS_ONE), RATE_MIN, RATE_MAX);
			outs[k] = v[RATE_W-1:0];
		end
		res.step_ticks = dt;
		res.rate_x = outs[0];
		res.rate_y = outs[1];
		res.rate_z = outs[2];
		res.is_still = still;
		return res;
	endfunction

	function automatic void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			REG_DEADBAND: cfg_deadband = data;
			REG_STILL:    cfg_still = data;
			REG_TICK_MIN: cfg_tick_min = data[TICK_W-1:0];
			REG_TICK_MAX: cfg_tick_max = data[TICK_W-1:0];
			REG_TICK_NOM: cfg_tick_nom = data[TICK_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void add_sample(logic [STAMP_W-1:0] st, int x, int y, int z,
			bit typed = 1'b0, rates_t w = '0);
		dir_row_t row;
		row.kind = ROW_SAMPLE;
		row.idx = '0;
		row.data = '0;
		row.smp.stamp = st;
		row.smp.gx = RATE_W'(x);
		row.smp.gy = RATE_W'(y);
		row.smp.gz = RATE_W'(z);
		row.typed = typed;
		row.want = w;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		dir_row_t row;
		row.kind = ROW_WRITE;
		row.idx = idx;
		row.data = data;
		row.smp = '0;
		row.typed = 1'b0;
		row.want = '0;
		dir_rows.push_back(row);
	endfunction

	// drop valid and wait until every result is back
	task automatic settle();
		@(negedge clk);
		imu_ch.valid = 1'b0;
		while (rates_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		note_write(idx, data);
		n_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic push_sample(sample_t s, bit typed, rates_t want);
		int     gap;
		rates_t pred;
		gap = steady ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			imu_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		imu_ch.valid = 1'b1;
		imu_ch.tick_stamp = s.stamp;
		imu_ch.gyro_x = s.gx;
		imu_ch.gyro_y = s.gy;
		imu_ch.gyro_z = s.gz;
		do
			@(posedge clk);
		while (imu_ch.ready !== 1'b1);
		pred = predict_conditioned(s);
		rates_due.push_back(typed ? want : pred);
		n_samples++;
	endtask

	initial begin : stimulus
		sample_t            s;
		logic [STAMP_W-1:0] stamp_now;
		logic [STAMP_W-1:0] diff;
		logic [CFG_W-1:0]   db, sl, tmin, tmax, tnom;
		int                 gyro [3];
		int                 lo_ok, r, v;
		imu_ch.valid = 1'b0;
		imu_ch.tick_stamp = '0;
		imu_ch.gyro_x = '0;
		imu_ch.gyro_y = '0;
		imu_ch.gyro_z = '0;

		add_sample(32'd20, 0, 0, 0, 1'b1, '{16'd20, 24'sd0, 24'sd0, 24'sd0, 1'b1});
		add_sample(32'd20, 8388607, 0, 0, 1'b1,
			'{16'd20, 24'sd8388264, 24'sd0, 24'sd0, 1'b0});
		add_sample(32'd120, -8388608, 8388607, -8388608, 1'b1,
			'{16'd100, -24'sd8388265, 24'sd8388264, -24'sd8388265, 1'b0});
		add_sample(32'd121, 0, 0, 0, 1'b1, '{16'd20, 24'sd0, 24'sd0, 24'sd0, 1'b1});
		add_sample(32'd222, 344, -343, 100);
		add_sample(32'd227, 1000, -1000, 500);
		add_sample(32'hFFFF_FFF0, -5, 7, -9);
		add_sample(32'h0000_0010, 0, 0, 0);
		add_write(REG_TICK_MIN, 23'd0);
		add_sample(32'h0000_0010, 200, -200, 0);
		add_write(REG_TICK_MIN, 23'd200);
		add_sample(32'd166, 50, 50, 50);
		add_write(REG_TICK_NOM, 23'd0);
		add_sample(32'd216, -1500, 1200, 800);
		add_write(REG_TICK_MAX, 23'd65535);
		add_write(REG_TICK_MIN, 23'd1);
		add_sample(32'd60216, 1000, -1000, 2000);
		add_write(REG_DEADBAND, 23'd0);
		add_write(REG_STILL, 23'h7FFFFF);
		add_sample(32'd60217, 4000000, -4000000, 123456);
		add_write(REG_DEADBAND, 23'h7FFFFF);
		add_sample(32'd60218, 8388607, -8388608, -1);
		add_write(REG_NONE_LO, 23'h7FFFFF);
		add_write(REG_NONE_HI, 23'd0);
		add_sample(32'd60219, 0, 0, 0);
		add_write(REG_STILL, 23'd0);
		add_sample(32'd60220, 0, 0, 0);
		add_write(REG_TICK_NOM, 23'd20);
		add_sample(32'd60300, -1, 1, -1);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				settle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				push_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
			end
		end
		stamp_now = last_stamp;

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					db = CFG_W'(343); sl = CFG_W'(2859);
					tmin = CFG_W'(5); tmax = CFG_W'(100); tnom = CFG_W'(20);
				end
				1: begin
					db = '0; sl = 23'h7FFFFF;
					tmin = CFG_W'(1); tmax = CFG_W'(65535); tnom = CFG_W'(65535);
				end
				2: begin
					db = 23'h7FFFFF; sl = '0;
					tmin = CFG_W'(65535); tmax = CFG_W'(65535); tnom = CFG_W'(1);
				end
				3: begin
					db = CFG_W'($urandom_range(0, 2000));
					sl = CFG_W'($urandom_range(0, 23'h7FFFFF));
					tmin = CFG_W'($urandom_range(1, 60));
					tmax = CFG_W'($urandom_range(1, 400));
					tnom = CFG_W'($urandom_range(0, 65535));
				end
				4: begin
					db = CFG_W'($urandom_range(0, 23'h7FFFFF));
					sl = CFG_W'($urandom_range(0, 23'h7FFFFF));
					tmin = CFG_W'($urandom_range(0, 65535));
					tmax = CFG_W'($urandom_range(0, 65535));
					tnom = CFG_W'($urandom_range(0, 65535));
				end
				default: begin
					db = CFG_W'(120); sl = CFG_W'(40000);
					tmin = CFG_W'(2); tmax = CFG_W'(40); tnom = CFG_W'(10);
				end
			endcase
			settle();
			write_reg(REG_DEADBAND, db);
			write_reg(REG_STILL, sl);
			write_reg(REG_TICK_MIN, tmin);
			write_reg(REG_TICK_MAX, tmax);
			write_reg(REG_TICK_NOM, tnom);
			if (ph == 3)
				write_reg(REG_NONE_LO, CFG_W'($urandom()));

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				steady = (i >= 90 && i < 120);
				if (ph == 0 && i == 60)
					long_hold = 300;

				case ($urandom_range(0, 9))
					7: diff = '0;
					8: diff = $urandom();
					9: diff = $urandom_range(0, 1000);
					default: begin
						lo_ok = (cfg_tick_min == 0) ? 1 : int'(cfg_tick_min);
						if (lo_ok <= int'(cfg_tick_max))
							diff = $urandom_range(lo_ok, cfg_tick_max);
						else
							diff = $urandom_range(1, 200);
					end
				endcase
				stamp_now = stamp_now + diff;

				case ($urandom_range(0, 9))
					6: begin
						for (int k = 0; k < 3; k++) begin
							v = int'(cfg_deadband) + int'($urandom_range(0, 8)) - 4;
							if (v > RATE_MAX)
								v = int'(RATE_MAX);
							gyro[k] = $urandom_range(0, 1) ? -v : v;
						end
					end
					7, 8: begin
						for (int k = 0; k < 3; k++)
							gyro[k] = int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
					end
					9: begin
						for (int k = 0; k < 3; k++)
							case ($urandom_range(0, 3))
								0: gyro[k] = -8388608;
								1: gyro[k] = 8388607;
								2: gyro[k] = 0;
								default: gyro[k] = -1;
							endcase
					end
					default: begin
						// inside the still limit when it is nonzero, so the bias tracks
						r = int'(cfg_still) / 2;
						for (int k = 0; k < 3; k++)
							gyro[k] = int'($urandom_range(0, 2 * r)) - r;
					end
				endcase

				s.stamp = stamp_now;
				s.gx = RATE_W'(gyro[0]);
				s.gy = RATE_W'(gyro[1]);
				s.gz = RATE_W'(gyro[2]);
				push_sample(s, 1'b0, '0);
			end
		end
		steady = 1'b0;

		@(negedge clk);
		imu_ch.valid = 1'b0;
		while (rates_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d samples over directed rows and %0d random phases: %0d tracking",
			n_samples, PHASES, n_still);
		$display("  bias, %0d on the nominal step, %0d register writes, %0d beats checked",
			n_fallback, n_writes, n_results);
		if (fault_count == 0 && rates_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : drain
		int pause;
		rate_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold > 0) begin
				pause = long_hold;
				long_hold = 0;
			end else begin
				pause = steady ? 0 : $urandom_range(0, 7);
			end
			@(negedge clk);
			if (pause > 0) begin
				rate_ch.ready = 1'b0;
				repeat (pause) @(negedge clk);
			end
			rate_ch.ready = 1'b1;
			do
				@(posedge clk);
			while (rate_ch.valid !== 1'b1);
		end
	end

	always @(posedge clk) begin : check_rates
		rates_t got;
		rates_t want;
		if (arst_n && rate_ch.valid === 1'b1 && rate_ch.ready === 1'b1) begin
			got.step_ticks = rate_ch.step_ticks;
			got.rate_x = rate_ch.rate_x;
			got.rate_y = rate_ch.rate_y;
			got.rate_z = rate_ch.rate_z;
			got.is_still = rate_ch.is_still;
			if (rates_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("beat %0d with none due: step %0d x %0d y %0d z %0d still %0b",
						n_results, got.step_ticks, got.rate_x, got.rate_y, got.rate_z,
						got.is_still);
			end else begin
				want = rates_due.pop_front();
				if (got.step_ticks !== want.step_ticks || got.rate_x !== want.rate_x ||
						got.rate_y !== want.rate_y || got.rate_z !== want.rate_z ||
						got.is_still !== want.is_still) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("beat %0d exp: step %0d x %0d y %0d z %0d still %0b",
							n_results, want.step_ticks, want.rate_x, want.rate_y,
							want.rate_z, want.is_still);
						$display("beat %0d got: step %0d x %0d y %0d z %0d still %0b",
							n_results, got.step_ticks, got.rate_x, got.rate_y,
							got.rate_z, got.is_still);
					end
				end
			end
			n_results++;
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("timeout with %0d results outstanding", rates_due.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
